// ----- sv/dlt_pkg.sv -----
`timescale 1ns / 1ps
package dlt_pkg;

  localparam int DivStages = 16;   // two quotient bits per stage
  localparam int Latency   = 27;   // accept edge to result strobe, in edges

  localparam logic [31:0] TimeStepReset = 32'd65536;
  localparam logic [16:0] DampReset     = 17'd13107;
  localparam logic signed [18:0] QOne   = 19'sd65536;

  localparam logic RegTimeStep = 1'b0;
  localparam logic RegDamping  = 1'b1;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] vel_in_x;
    logic signed [31:0] vel_in_y;
    logic signed [31:0] vel_in_z;
    logic signed [31:0] pos_in_x;
    logic signed [31:0] pos_in_y;
    logic signed [31:0] pos_in_z;
    logic [30:0]        mass;
    logic [2:0]         blocked_axes;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_out_x;
    logic signed [31:0] vel_out_y;
    logic signed [31:0] vel_out_z;
    logic signed [31:0] pos_out_x;
    logic signed [31:0] pos_out_y;
    logic signed [31:0] pos_out_z;
    logic [62:0]        speed_squared;
  } res_item_t;

  // per-axis data that rides alongside the divider
  typedef struct packed {
    logic signed [31:0] vel;
    logic signed [31:0] pos;
    logic               f_neg;
    logic               f_zero;
    logic               blk;
  } side_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] nv;
    logic signed [31:0] np;
    logic [62:0]        sq;
  } axis_res_t;

  // one restoring step: returns {remainder, quotient bit}
  function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                           input logic [30:0] d);
    logic [31:0] rr;
    rr = {r[30:0], b};
    if (rr >= {1'b0, d}) begin
      return {rr - {1'b0, d}, 1'b1};
    end else begin
      return {rr, 1'b0};
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

// ----- sv/dlt_div.sv -----
`timescale 1ns / 1ps
module dlt_div import dlt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic signed [31:0] force_i,
  input  logic [30:0]        mass_i,
  input  side_t              side_i,
  output logic               vld_o,
  output logic signed [31:0] acc_o,
  output side_t              side_o
);

  logic [31:0] r_q    [DivStages+1];
  logic [31:0] n_q    [DivStages+1];
  logic [31:0] quo_q  [DivStages+1];
  logic [30:0] m_q    [DivStages+1];
  logic        ovf_q  [DivStages+1];
  logic        neg_q  [DivStages+1];
  logic        mz_q   [DivStages+1];
  side_t       side_q [DivStages+1];
  logic        vld_q  [DivStages+1];

  logic [31:0] fabs;
  assign fabs = force_i[31] ? 32'(-force_i) : 32'(force_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  // quotient would reach 2^32 when |f| >> 16 >= mass
  always_ff @(posedge clk_i) begin
    r_q[0]    <= {16'd0, fabs[31:16]};
    n_q[0]    <= {fabs[15:0], 16'd0};
    quo_q[0]  <= '0;
    m_q[0]    <= mass_i;
    ovf_q[0]  <= {15'd0, fabs[31:16]} >= mass_i;
    neg_q[0]  <= force_i[31];
    mz_q[0]   <= (mass_i == '0);
    side_q[0] <= side_i;
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_stage
    logic [32:0] s1, s2;
    always_comb begin
      s1 = div_step(r_q[k-1], n_q[k-1][31], m_q[k-1]);
      s2 = div_step(s1[32:1], n_q[k-1][30], m_q[k-1]);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      r_q[k]    <= s2[32:1];
      n_q[k]    <= {n_q[k-1][29:0], 2'b00};
      quo_q[k]  <= {quo_q[k-1][29:0], s1[0], s2[0]};
      m_q[k]    <= m_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      mz_q[k]   <= mz_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  logic signed [31:0] acc_d, acc_q;
  logic               vld_out_q;
  side_t              side_out_q;
  logic [31:0]        qf;

  always_comb begin
    qf = quo_q[DivStages];
    if (mz_q[DivStages]) begin
      acc_d = '0;
    end else if (neg_q[DivStages]) begin
      if (ovf_q[DivStages] || qf > 32'h80000000) begin
        acc_d = 32'sh80000000;
      end else begin
        acc_d = 32'(-qf);
      end
    end else begin
      if (ovf_q[DivStages] || qf > 32'h7FFFFFFF) begin
        acc_d = 32'sh7FFFFFFF;
      end else begin
        acc_d = qf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    side_out_q <= side_q[DivStages];
  end

  assign vld_o  = vld_out_q;
  assign acc_o  = acc_q;
  assign side_o = side_out_q;

endmodule

// ----- sv/dlt_update.sv -----
`timescale 1ns / 1ps
module dlt_update import dlt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic signed [31:0] acc_i,
  input  side_t              side_i,
  input  logic [31:0]        dt_i,
  input  logic [16:0]        damp_i,
  output axis_res_t          res_o
);

  logic [8:1] vld_q;
  side_t      side1_q, side2_q, side3_q, side4_q, side5_q;
  logic signed [31:0] pos6_q, pos7_q;

  logic signed [32:0] dts;
  assign dts = signed'({1'b0, dt_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:1], vld_i};
    end
  end

  // stage 1: a * dt
  logic signed [31:0] a1_q;
  logic signed [63:0] p1_q;
  logic signed [64:0] p1_full;
  assign p1_full = acc_i * dts;
  always_ff @(posedge clk_i) begin
    a1_q    <= acc_i;
    p1_q    <= p1_full[63:0];
    side1_q <= side_i;
  end

  // stage 2: damping test value and factor
  logic signed [32:0] tval;
  logic signed [30:0] half;
  logic signed [18:0] fac_d, fac_q;
  logic signed [31:0] a2_q;
  logic               f_pos, t_pos, t_neg;
  always_comb begin
    half  = p1_q[63:33];
    tval  = 33'(side1_q.vel) + 33'(half);
    f_pos = !side1_q.f_neg && !side1_q.f_zero;
    t_pos = !tval[32] && (tval != '0);
    t_neg = tval[32];
    if ((f_pos && t_pos) || (side1_q.f_neg && t_neg)) begin
      fac_d = QOne - signed'({2'b00, damp_i});
    end else if ((f_pos && t_neg) || (side1_q.f_neg && t_pos)) begin
      fac_d = QOne + signed'({2'b00, damp_i});
    end else begin
      fac_d = QOne;
    end
  end
  always_ff @(posedge clk_i) begin
    a2_q    <= a1_q;
    fac_q   <= fac_d;
    side2_q <= side1_q;
  end

  // stage 3: a * factor
  logic signed [50:0] p3_q;
  always_ff @(posedge clk_i) begin
    p3_q    <= a2_q * fac_q;
    side3_q <= side2_q;
  end

  // stage 4: scale back, saturate, drop blocked axis
  logic signed [31:0] a4_q;
  logic signed [34:0] sh4;
  assign sh4 = p3_q[50:16];
  always_ff @(posedge clk_i) begin
    a4_q    <= side3_q.blk ? 32'sd0 : sat32(36'(sh4));
    side4_q <= side3_q;
  end

  // stage 5: a * dt
  logic signed [63:0] p5_q;
  logic signed [64:0] p5_full;
  assign p5_full = a4_q * dts;
  always_ff @(posedge clk_i) begin
    p5_q    <= p5_full[63:0];
    side5_q <= side4_q;
  end

  // stage 6: new velocity
  logic signed [31:0] nv6_q;
  logic signed [32:0] sum6;
  assign sum6 = 33'(side5_q.vel) + 33'($signed(p5_q[63:32]));
  always_ff @(posedge clk_i) begin
    nv6_q  <= sat32(36'(sum6));
    pos6_q <= side5_q.pos;
  end

  // stage 7: v * dt and v^2
  logic signed [63:0] p7_q, sq7_q;
  logic signed [31:0] nv7_q;
  logic signed [64:0] p7_full;
  assign p7_full = nv6_q * dts;
  always_ff @(posedge clk_i) begin
    p7_q   <= p7_full[63:0];
    sq7_q  <= nv6_q * nv6_q;
    nv7_q  <= nv6_q;
    pos7_q <= pos6_q;
  end

  // stage 8: new position
  logic signed [32:0] sum8;
  logic signed [31:0] nv8_q, np8_q;
  logic [62:0]        sq8_q;
  assign sum8 = 33'(pos7_q) + 33'($signed(p7_q[63:32]));
  always_ff @(posedge clk_i) begin
    nv8_q <= nv7_q;
    np8_q <= sat32(36'(sum8));
    sq8_q <= sq7_q[62:0];
  end

  always_comb begin
    res_o.vld = vld_q[8];
    res_o.nv  = nv8_q;
    res_o.np  = np8_q;
    res_o.sq  = sq8_q;
  end

endmodule

// ----- sv/damped_leapfrog_translate_top.sv -----
`timescale 1ns / 1ps
// A particle accepted with start passes the divider input register, the divider stages,
// the divider output register, the update stages and the output register before valid_o rises.
// Throughput: one particle per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 16-stage restoring divider (two quotient bits per stage)
// followed by eight multiply and saturate stages.
// Reset: rst_ni clears all valid bits and loads time_step and damping_factor defaults.
module damped_leapfrog_translate_top import dlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_i,
  output logic        valid_o,
  output res_item_t   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] dt_q;
  logic [16:0] damp_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= TimeStepReset;
      damp_q <= DampReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegTimeStep: dt_q   <= pwdata;
        RegDamping:  damp_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegTimeStep: prdata = dt_q;
      RegDamping:  prdata = {15'd0, damp_q};
      default:     prdata = '0;
    endcase
  end

  logic acc_ok;
  assign acc_ok = start && !busy;

  logic signed [31:0] f_ax [3];
  side_t              s_in [3];
  always_comb begin
    f_ax[0] = in_i.force_x;
    f_ax[1] = in_i.force_y;
    f_ax[2] = in_i.force_z;
    s_in[0] = '{in_i.vel_in_x, in_i.pos_in_x, in_i.force_x[31],
                in_i.force_x == '0, in_i.blocked_axes[0]};
    s_in[1] = '{in_i.vel_in_y, in_i.pos_in_y, in_i.force_y[31],
                in_i.force_y == '0, in_i.blocked_axes[1]};
    s_in[2] = '{in_i.vel_in_z, in_i.pos_in_z, in_i.force_z[31],
                in_i.force_z == '0, in_i.blocked_axes[2]};
  end

  axis_res_t ax [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic               dv;
    logic signed [31:0] da;
    side_t              ds;
    dlt_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .vld_i   (acc_ok),
      .force_i (f_ax[i]),
      .mass_i  (in_i.mass),
      .side_i  (s_in[i]),
      .vld_o   (dv),
      .acc_o   (da),
      .side_o  (ds)
    );
    dlt_update u_upd (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv),
      .acc_i  (da),
      .side_i (ds),
      .dt_i   (dt_q),
      .damp_i (damp_q),
      .res_o  (ax[i])
    );
  end

  logic [64:0] sum;
  assign sum = 65'(ax[0].sq) + 65'(ax[1].sq) + 65'(ax[2].sq);

  logic      vld_q;
  res_item_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ax[0].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.vel_out_x     <= ax[0].nv;
    res_q.vel_out_y     <= ax[1].nv;
    res_q.vel_out_z     <= ax[2].nv;
    res_q.pos_out_x     <= ax[0].np;
    res_q.pos_out_y     <= ax[1].np;
    res_q.pos_out_z     <= ax[2].np;
    res_q.speed_squared <= (sum[64:63] != 2'b00) ? {63{1'b1}} : sum[62:0];
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ax[0].vld == ax[1].vld) && (ax[1].vld == ax[2].vld))
    else $error("axis lanes out of step");

  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, Latency))
    else $error("result strobe without an accepted transfer");

  a_speed_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ax[0].vld && (sum[64:63] != 2'b00) |=> res_o.speed_squared == {63{1'b1}})
    else $error("speed not saturated");

endmodule
